/* sv/cvs_pkg.sv */
// ----------------------------------------------------------------------------
// cvs_pkg
// Shared widths and defaults for the cell voltage statistics core.
// ----------------------------------------------------------------------------
package cvs_pkg;

  // field widths
  localparam int CELL_W = 16;
  localparam int POS_W  = 6;
  localparam int SUM_W  = 21;

  // default report length limit
  localparam int MAX_CELLS_DEF = 32;

  // divider step counter width
  localparam int STEP_W = $clog2(SUM_W);

endpackage

/* sv/cell_voltage_statistics_core.sv */
// ----------------------------------------------------------------------------
// cell_voltage_statistics_core
// Running min, max, positions, sum and count over one pack report, with a
// min/max/delta/average result on the last cell of each report.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | in_valid/in_stall  | cell_mv, last_cell
//  out     | output    | out_valid/out_stall| report_valid, min/max, positions,
//          |           |                    | delta, average, cell_count
//
//  A cell that is not the last one is captured on the transfer and applied in
//  the update state. The last cell of a valid report then runs the restoring
//  subtract unit over the SUM_W-bit sum to form the average, and the result
//  is then loaded into the output register; a rejected report skips the divide.
//  The result sits in an output register, so the next report starts while it
//  waits; a new last cell waits only if the previous result is still held.
//  rst_n is synchronous and active low; it clears the sequencer, the
//  accumulators and out_valid.
//
module cell_voltage_statistics_core #(
  parameter int MAX_CELLS = cvs_pkg::MAX_CELLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cvs_pkg::CELL_W-1:0] in_cell_mv,
  input  logic                       in_last_cell,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_report_valid,
  output logic [cvs_pkg::CELL_W-1:0] out_min_mv,
  output logic [cvs_pkg::CELL_W-1:0] out_max_mv,
  output logic [cvs_pkg::POS_W-1:0]  out_min_position,
  output logic [cvs_pkg::POS_W-1:0]  out_max_position,
  output logic [cvs_pkg::CELL_W-1:0] out_delta_mv,
  output logic [cvs_pkg::CELL_W-1:0] out_average_mv,
  output logic [cvs_pkg::POS_W-1:0]  out_cell_count
);
  import cvs_pkg::*;

  localparam logic [POS_W-1:0]  MaxCnt   = POS_W'(MAX_CELLS);
  localparam logic [POS_W-1:0]  OverCnt  = POS_W'(MAX_CELLS + 1);
  localparam logic [CELL_W:0]   MinReset = {1'b1, {CELL_W{1'b0}}};
  localparam logic [STEP_W-1:0] LastStep = STEP_W'(SUM_W - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_UPDATE = 2'd1;
  localparam logic [1:0] S_DIVIDE = 2'd2;
  localparam logic [1:0] S_WAIT   = 2'd3;

  logic [1:0]        state_r, state_nxt;

  // captured input item
  logic [CELL_W-1:0] cell_r;
  logic              last_r;

  // accumulators
  logic [CELL_W:0]   min_r, min_nxt;
  logic [CELL_W-1:0] max_r, max_nxt;
  logic [POS_W-1:0]  min_pos_r, min_pos_nxt;
  logic [POS_W-1:0]  max_pos_r, max_pos_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [POS_W-1:0]  count_r, count_nxt;

  // divide unit
  logic [SUM_W-1:0]  div_q_r, div_q_nxt;
  logic [POS_W-1:0]  div_rem_r, div_rem_nxt;
  logic [POS_W-1:0]  div_den_r, div_den_nxt;
  logic [STEP_W-1:0] div_step_r, div_step_nxt;
  logic [POS_W:0]    rem_shift;
  logic [POS_W+1:0]  rem_diff;

  // output register
  logic              out_valid_r;
  logic              out_report_valid_r;
  logic [CELL_W-1:0] out_min_r, out_max_r, out_delta_r, out_avg_r;
  logic [POS_W-1:0]  out_min_pos_r, out_max_pos_r, out_count_r;

  logic in_xfer, out_free, load_out, report_ok;

  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign load_out  = (state_r == S_WAIT) && out_free;
  assign report_ok = (count_r != 0) && (count_r <= MaxCnt);
  assign in_stall  = (state_r != S_IDLE);

  // one restoring divide step: shift in a dividend bit, trial subtract
  assign rem_shift = {div_rem_r, div_q_r[SUM_W-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, div_den_r};

  // accumulator update for the captured cell
  always_comb begin
    min_nxt     = min_r;
    max_nxt     = max_r;
    min_pos_nxt = min_pos_r;
    max_pos_nxt = max_pos_r;
    sum_nxt     = sum_r;
    count_nxt   = count_r;
    if (count_r < MaxCnt) begin
      sum_nxt   = sum_r + SUM_W'(cell_r);
      count_nxt = count_r + POS_W'(1);
      if ({1'b0, cell_r} < min_r) begin
        min_nxt     = {1'b0, cell_r};
        min_pos_nxt = count_r + POS_W'(1);
      end
      if (cell_r > max_r) begin
        max_nxt     = cell_r;
        max_pos_nxt = count_r + POS_W'(1);
      end
    end else begin
      count_nxt = OverCnt;
    end
  end

  // sequencer and divide unit control
  always_comb begin
    state_nxt    = state_r;
    div_q_nxt    = div_q_r;
    div_rem_nxt  = div_rem_r;
    div_den_nxt  = div_den_r;
    div_step_nxt = div_step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (count_nxt > MaxCnt) begin
          state_nxt = S_WAIT;
        end else begin
          div_q_nxt    = sum_nxt;
          div_rem_nxt  = '0;
          div_den_nxt  = count_nxt;
          div_step_nxt = LastStep;
          state_nxt    = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (!rem_diff[POS_W+1]) begin
          div_rem_nxt = rem_diff[POS_W-1:0];
          div_q_nxt   = {div_q_r[SUM_W-2:0], 1'b1};
        end else begin
          div_rem_nxt = rem_shift[POS_W-1:0];
          div_q_nxt   = {div_q_r[SUM_W-2:0], 1'b0};
        end
        div_step_nxt = div_step_r - STEP_W'(1);
        if (div_step_r == '0) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      min_r       <= MinReset;
      max_r       <= '0;
      min_pos_r   <= '0;
      max_pos_r   <= '0;
      sum_r       <= '0;
      count_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_UPDATE) begin
        min_r     <= min_nxt;
        max_r     <= max_nxt;
        min_pos_r <= min_pos_nxt;
        max_pos_r <= max_pos_nxt;
        sum_r     <= sum_nxt;
        count_r   <= count_nxt;
      end else if (load_out) begin
        min_r     <= MinReset;
        max_r     <= '0;
        min_pos_r <= '0;
        max_pos_r <= '0;
        sum_r     <= '0;
        count_r   <= '0;
      end
    end
  end

  // input capture and divide unit registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cell_r <= in_cell_mv;
      last_r <= in_last_cell;
    end
    div_q_r    <= div_q_nxt;
    div_rem_r  <= div_rem_nxt;
    div_den_r  <= div_den_nxt;
    div_step_r <= div_step_nxt;
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_report_valid_r <= report_ok;
      if (report_ok) begin
        out_min_r     <= min_r[CELL_W-1:0];
        out_max_r     <= max_r;
        out_min_pos_r <= min_pos_r;
        out_max_pos_r <= max_pos_r;
        out_delta_r   <= max_r - min_r[CELL_W-1:0];
        out_avg_r     <= div_q_r[CELL_W-1:0];
        out_count_r   <= count_r;
      end else begin
        out_min_r     <= '0;
        out_max_r     <= '0;
        out_min_pos_r <= '0;
        out_max_pos_r <= '0;
        out_delta_r   <= '0;
        out_avg_r     <= '0;
        out_count_r   <= OverCnt;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_report_valid = out_report_valid_r;
  assign out_min_mv       = out_min_r;
  assign out_max_mv       = out_max_r;
  assign out_min_position = out_min_pos_r;
  assign out_max_position = out_max_pos_r;
  assign out_delta_mv     = out_delta_r;
  assign out_average_mv   = out_avg_r;
  assign out_cell_count   = out_count_r;

endmodule

/* sv/cvs_checker.sv */
// ----------------------------------------------------------------------------
// cvs_checker
// Port-level checks on the cell voltage statistics core, bound to the top.
// ----------------------------------------------------------------------------
module cvs_checker #(
  parameter int MAX_CELLS = cvs_pkg::MAX_CELLS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_report_valid,
  input logic [cvs_pkg::CELL_W-1:0] out_min_mv,
  input logic [cvs_pkg::CELL_W-1:0] out_max_mv,
  input logic [cvs_pkg::POS_W-1:0]  out_min_position,
  input logic [cvs_pkg::POS_W-1:0]  out_max_position,
  input logic [cvs_pkg::CELL_W-1:0] out_delta_mv,
  input logic [cvs_pkg::CELL_W-1:0] out_average_mv,
  input logic [cvs_pkg::POS_W-1:0]  out_cell_count
);
  import cvs_pkg::*;

  localparam logic [POS_W-1:0] MaxCnt  = POS_W'(MAX_CELLS);
  localparam logic [POS_W-1:0] OverCnt = POS_W'(MAX_CELLS + 1);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // each cell transfer is followed by an update cycle
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  // rejected report carries only the saturated count
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_report_valid |->
      out_cell_count == OverCnt && out_min_mv == '0 && out_max_mv == '0 &&
      out_delta_mv == '0 && out_average_mv == '0 &&
      out_min_position == '0 && out_max_position == '0)
    else $error("rejected report has nonzero fields");

  // valid report is self-consistent
  a_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_report_valid |->
      out_cell_count != '0 && out_cell_count <= MaxCnt &&
      out_min_mv <= out_max_mv && out_delta_mv == CELL_W'(out_max_mv - out_min_mv) &&
      out_average_mv >= out_min_mv && out_average_mv <= out_max_mv &&
      out_min_position != '0 && out_min_position <= out_cell_count &&
      out_max_position <= out_cell_count)
    else $error("inconsistent report fields");

endmodule

bind cell_voltage_statistics_core cvs_checker #(.MAX_CELLS(MAX_CELLS)) u_cvs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_report_valid (out_report_valid),
  .out_min_mv       (out_min_mv),
  .out_max_mv       (out_max_mv),
  .out_min_position (out_min_position),
  .out_max_position (out_max_position),
  .out_delta_mv     (out_delta_mv),
  .out_average_mv   (out_average_mv),
  .out_cell_count   (out_cell_count)
);

/* bench/cell_voltage_statistics_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_voltage_statistics_core_tb
// Drives pack reports of cell voltages into the statistics core. A tracker
// keeps its own running min, max, positions, sum and count, and checks every
// summary transfer field by field against the oldest predicted summary.
// Both sides idle at random, and the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module cell_voltage_statistics_core_tb;
  import cvs_pkg::*;

  localparam int N_CELLS = MAX_CELLS_DEF;

  // one summary transfer, field order as on the result ports
  typedef struct packed {
    logic              report_valid;
    logic [CELL_W-1:0] min_mv;
    logic [CELL_W-1:0] max_mv;
    logic [POS_W-1:0]  min_position;
    logic [POS_W-1:0]  max_position;
    logic [CELL_W-1:0] delta_mv;
    logic [CELL_W-1:0] average_mv;
    logic [POS_W-1:0]  cell_count;
  } pack_summary_t;

  typedef enum int {VS_UNIFORM, VS_NOMINAL, VS_ZERO, VS_FULL, VS_MIXED} value_style_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  // running pack statistics and the summaries they predict
  class pack_stats_tracker;
    logic [CELL_W:0]   low_mv;
    logic [CELL_W-1:0] high_mv;
    logic [POS_W-1:0]  low_pos;
    logic [POS_W-1:0]  high_pos;
    logic [POS_W-1:0]  cells_seen;
    logic [SUM_W-1:0]  mv_sum;
    pack_summary_t     expected_summaries[$];
    int unsigned       errors;
    int unsigned       reports;
    int unsigned       rejected;
    int unsigned       compared;

    function new();
      clear();
      errors   = 0;
      reports  = 0;
      rejected = 0;
      compared = 0;
    endfunction

    function void clear();
      low_mv     = {1'b1, {CELL_W{1'b0}}};
      high_mv    = '0;
      low_pos    = '0;
      high_pos   = '0;
      cells_seen = '0;
      mv_sum     = '0;
    endfunction

    // accumulate one accepted cell; a last cell closes the report
    function void take_cell(logic [CELL_W-1:0] mv, logic last);
      pack_summary_t    s;
      logic [POS_W-1:0] pos;
      logic [SUM_W-1:0] avg;
      if (cells_seen < N_CELLS) begin
        pos    = cells_seen + 1'b1;
        mv_sum = mv_sum + mv;
        // strict compares, so a tie keeps the first position
        if ({1'b0, mv} < low_mv) begin
          low_mv  = {1'b0, mv};
          low_pos = pos;
        end
        if (mv > high_mv) begin
          high_mv  = mv;
          high_pos = pos;
        end
        cells_seen = pos;
      end else begin
        cells_seen = POS_W'(N_CELLS + 1);
      end
      if (!last) return;

      s = '0;
      if (cells_seen > N_CELLS || cells_seen == 0) begin
        // oversized report: only the saturated count is reported
        s.cell_count = POS_W'(N_CELLS + 1);
        rejected++;
      end else begin
        avg            = mv_sum / cells_seen;
        s.report_valid = 1'b1;
        s.min_mv       = low_mv[CELL_W-1:0];
        s.max_mv       = high_mv;
        s.min_position = low_pos;
        s.max_position = high_pos;
        s.delta_mv     = (high_mv >= low_mv[CELL_W-1:0]) ? high_mv - low_mv[CELL_W-1:0] : '0;
        s.average_mv   = avg[CELL_W-1:0];
        s.cell_count   = cells_seen;
      end
      expected_summaries.push_back(s);
      reports++;
      clear();
    endfunction

    function void field_mismatch(string name, logic [CELL_W-1:0] want, logic [CELL_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    endfunction

    // compare one summary transfer with the oldest prediction
    function void check_summary(pack_summary_t got);
      pack_summary_t want;
      if (expected_summaries.size() == 0) begin
        errors++;
        $display("%0t: summary with none expected, expected nothing actual %p", $time, got);
        return;
      end
      want = expected_summaries.pop_front();
      compared++;
      if (got.report_valid !== want.report_valid)
        field_mismatch("report_valid", want.report_valid, got.report_valid);
      if (got.min_mv !== want.min_mv)
        field_mismatch("min_mv", want.min_mv, got.min_mv);
      if (got.max_mv !== want.max_mv)
        field_mismatch("max_mv", want.max_mv, got.max_mv);
      if (got.min_position !== want.min_position)
        field_mismatch("min_position", want.min_position, got.min_position);
      if (got.max_position !== want.max_position)
        field_mismatch("max_position", want.max_position, got.max_position);
      if (got.delta_mv !== want.delta_mv)
        field_mismatch("delta_mv", want.delta_mv, got.delta_mv);
      if (got.average_mv !== want.average_mv)
        field_mismatch("average_mv", want.average_mv, got.average_mv);
      if (got.cell_count !== want.cell_count)
        field_mismatch("cell_count", want.cell_count, got.cell_count);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CELL_W-1:0] in_cell_mv = '0;
  logic              in_last_cell = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_report_valid;
  logic [CELL_W-1:0] out_min_mv;
  logic [CELL_W-1:0] out_max_mv;
  logic [POS_W-1:0]  out_min_position;
  logic [POS_W-1:0]  out_max_position;
  logic [CELL_W-1:0] out_delta_mv;
  logic [CELL_W-1:0] out_average_mv;
  logic [POS_W-1:0]  out_cell_count;

  pack_stats_tracker stats;
  int unsigned       cells_sent = 0;
  int unsigned       burst_left = 0;
  int unsigned       hold_cycles = 0;
  bit                long_hold_done = 1'b0;
  stall_mode_t       stall_mode = STALL_NONE;
  int unsigned       mode_left = 0;

  cell_voltage_statistics_core #(
    .MAX_CELLS(N_CELLS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cell_mv       (in_cell_mv),
    .in_last_cell     (in_last_cell),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_report_valid (out_report_valid),
    .out_min_mv       (out_min_mv),
    .out_max_mv       (out_max_mv),
    .out_min_position (out_min_position),
    .out_max_position (out_max_position),
    .out_delta_mv     (out_delta_mv),
    .out_average_mv   (out_average_mv),
    .out_cell_count   (out_cell_count)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // offer one cell and hold it until the transfer; bursts with random gaps
  task automatic send_cell(input logic [CELL_W-1:0] mv, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_cell_mv   <= mv;
    in_last_cell <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    stats.take_cell(mv, last);
    cells_sent++;
  endtask

  // one report of n_cells cells, last cell flagged
  task automatic send_report(input int unsigned n_cells, input value_style_t style);
    logic [CELL_W-1:0] mv;
    for (int unsigned i = 1; i <= n_cells; i++) begin
      case (style)
        VS_UNIFORM: mv = CELL_W'($urandom);
        VS_NOMINAL: mv = CELL_W'(3300 + 25 * $urandom_range(0, 6));
        VS_ZERO:    mv = '0;
        VS_FULL:    mv = '1;
        default: begin
          case ($urandom_range(0, 5))
            0:       mv = '0;
            1:       mv = '1;
            2:       mv = CELL_W'(1);
            3:       mv = {1'b1, {(CELL_W-1){1'b0}}};
            default: mv = CELL_W'($urandom);
          endcase
        end
      endcase
      send_cell(mv, i == n_cells);
    end
  endtask

  // stop offering until every predicted summary has been checked
  task automatic wait_for_summaries();
    in_valid <= 1'b0;
    do @(posedge clk); while (stats.expected_summaries.size() != 0);
  endtask

  // receiver: check transfers, stall on a changing pattern, one long hold-off
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall == 1'b0)
      stats.check_summary('{out_report_valid, out_min_mv, out_max_mv, out_min_position,
                            out_max_position, out_delta_mv, out_average_mv, out_cell_count});
    if (hold_cycles != 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && stats.compared >= 12) begin
      long_hold_done = 1'b1;
      hold_cycles    = 400;
      out_stall     <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        default:     out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // stimulus
  initial begin
    int unsigned n;
    int unsigned pick;
    bit          drained_once;
    drained_once = 1'b0;
    stats = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-cell reports at both extremes; all-zero report
    send_cell('0, 1'b1);
    send_cell('1, 1'b1);
    send_report(3, VS_ZERO);
    // ties on both min and max keep the first position
    send_cell(CELL_W'(3300), 1'b0);
    send_cell(CELL_W'(3100), 1'b0);
    send_cell(CELL_W'(3500), 1'b0);
    send_cell(CELL_W'(3100), 1'b0);
    send_cell(CELL_W'(3500), 1'b0);
    send_cell(CELL_W'(3300), 1'b1);
    // widest delta, and a low cell after two full-scale cells
    send_cell('0, 1'b0);
    send_cell('1, 1'b1);
    send_cell('1, 1'b0);
    send_cell('1, 1'b0);
    send_cell(CELL_W'(1), 1'b1);

    // largest sum, then one cell over the limit
    send_report(N_CELLS, VS_FULL);
    send_report(N_CELLS + 1, VS_UNIFORM);

    // random reports, mostly short, a few full or oversized
    while (cells_sent < 500) begin
      pick = $urandom_range(0, 99);
      if (pick < 65)      n = $urandom_range(1, 8);
      else if (pick < 88) n = $urandom_range(9, N_CELLS - 1);
      else if (pick < 94) n = N_CELLS;
      else                n = $urandom_range(N_CELLS + 1, N_CELLS + 8);
      send_report(n, value_style_t'($urandom_range(0, 4)));
      if (!drained_once && cells_sent >= 250) begin
        drained_once = 1'b1;
        wait_for_summaries();
      end
    end

    wait_for_summaries();
    repeat (SUM_W + 8) @(posedge clk);
    $display("covered %0d cells in %0d reports, %0d of them oversized;", cells_sent,
             stats.reports, stats.rejected);
    $display("%0d summary transfers compared, %0d mismatches", stats.compared, stats.errors);
    if (stats.errors == 0 && stats.expected_summaries.size() == 0) begin
      $display("** cell_voltage_statistics_core: PASSED **");
    end else begin
      $display("** cell_voltage_statistics_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d summaries outstanding", stats.expected_summaries.size());
    $display("** cell_voltage_statistics_core: FAILED **");
    $finish;
  end

endmodule
